// ===== design/trm_pkg.sv =====
`default_nettype none

package trm_pkg;

   localparam int AXES         = 3;
   localparam int SAMPLE_W     = 16;
   localparam int MEAN_W       = 24;
   localparam int CSR_W        = 6;
   localparam int LEN_MIN      = 3;
   localparam int WINDOW_RESET = 12;

   typedef logic signed [SAMPLE_W-1:0]     sample_type;
   typedef logic signed [MEAN_W-1:0]       mean_type;
   typedef logic [AXES-1:0][SAMPLE_W-1:0]  triple_type;
   typedef logic [CSR_W-1:0]               csr_type;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;
   localparam mean_type   MEAN_MAX   = 24'sh7FFFFF;
   localparam mean_type   MEAN_MIN   = 24'sh800000;

   // Per-axis unit control, one strobe per phase
   typedef struct packed {
      logic clear;   // start a new scan
      logic acc;     // fold the tail sample into sum, min and max
      logic load;    // trim and load the divider
      logic step;    // one restoring divide step
   } axis_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== design/trm_cell.sv =====
`default_nettype none

module trm_cell (
   input  wire logic               clock,
   input  wire logic               shift_en,
   input  wire trm_pkg::triple_type d,
   output      trm_pkg::triple_type q
);
   import trm_pkg::*;

   triple_type data_ff;

   // hold unless the chain advances
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= d;
      end
   end

   assign q = data_ff;

endmodule

`default_nettype wire

// ===== design/trm_axis.sv =====
`default_nettype none

module trm_axis #(
   parameter int WINDOW_MAX    = 32,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                              clock,
   input  wire trm_pkg::axis_ctrl_type            ctrl,
   input  wire trm_pkg::sample_type               sample,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]   divisor,
   output      trm_pkg::mean_type                 mean
);
   import trm_pkg::*;

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX) + 1;
   localparam int DIV_W = SUM_W + FRACTION_BITS;
   localparam int OW    = ((DIV_W > MEAN_W) ? DIV_W : MEAN_W) + 1;
   localparam logic [OW-1:0] NEG_LIM = OW'(1) << (MEAN_W - 1);
   localparam logic [OW-1:0] POS_LIM = NEG_LIM - OW'(1);

   logic signed [SUM_W-1:0] sum_ff;
   sample_type              min_ff;
   sample_type              max_ff;
   logic                    neg_ff;
   logic [DIV_W-1:0]        quo_ff;
   logic [LEN_W-1:0]        rem_ff;

   logic signed [SUM_W-1:0] trimmed;
   logic [SUM_W-1:0]        mag;
   logic [LEN_W:0]          trial;
   logic [OW-1:0]           quo_ext;

   always_comb begin
      trimmed = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);
      mag     = trimmed[SUM_W-1] ? SUM_W'(-trimmed) : trimmed;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         sum_ff <= '0;
         min_ff <= SAMPLE_MAX;
         max_ff <= SAMPLE_MIN;
      end
      if (ctrl.acc) begin
         sum_ff <= sum_ff + SUM_W'(sample);
         if (sample < min_ff) begin
            min_ff <= sample;
         end
         if (sample > max_ff) begin
            max_ff <= sample;
         end
      end
      if (ctrl.load) begin
         neg_ff <= trimmed[SUM_W-1];
         quo_ff <= DIV_W'(mag) << FRACTION_BITS;
         rem_ff <= '0;
      end
      if (ctrl.step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_ff <= LEN_W'(trial - {1'b0, divisor});
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= LEN_W'(trial);
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   // restore the sign and clamp to the output range
   always_comb begin
      quo_ext = OW'(quo_ff);
      if (neg_ff) begin
         if (quo_ext > NEG_LIM) begin
            mean = MEAN_MIN;
         end else begin
            mean = MEAN_W'(-quo_ext);
         end
      end else begin
         if (quo_ext > POS_LIM) begin
            mean = MEAN_MAX;
         end else begin
            mean = MEAN_W'(quo_ext);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/trimmed_mean_window_filter_xyz.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_sample_x/y/z, 16-bit signed
// rsp_      out        rsp_valid/rsp_stall  rsp_mean_x/y/z, 24-bit signed, FRACTION_BITS frac
// csr_      in         csr_wr_en            csr_wr_data, window length (6 bits)
//
// A fill-phase request is taken without a stall; one that yields a result holds req_stall
// high through the n-sample scan, the trim, one divide step per quotient bit and the load,
// longer while a stalled result blocks the load.
// Reset is synchronous and clears control state only; window cells are never cleared.
// A stalled result holds in the output register; the next request is taken meanwhile.
`default_nettype none

module trimmed_mean_window_filter_xyz #(
   parameter int WINDOW_MAX    = 32,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire trm_pkg::sample_type req_sample_x,
   input  wire trm_pkg::sample_type req_sample_y,
   input  wire trm_pkg::sample_type req_sample_z,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      trm_pkg::mean_type   rsp_mean_x,
   output      trm_pkg::mean_type   rsp_mean_y,
   output      trm_pkg::mean_type   rsp_mean_z,
   input  wire logic                csr_wr_en,
   input  wire trm_pkg::csr_type    csr_wr_data
);
   import trm_pkg::*;

   localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX) + 1;
   localparam int DIV_W  = SUM_W + FRACTION_BITS;
   localparam int DCNT_W = $clog2(DIV_W);
   localparam int CMP_W  = (LEN_W > CSR_W) ? LEN_W : CSR_W;

   // control state
   state_type         state_ff,    state_in;
   csr_type           len_ff;
   logic [LEN_W-1:0]  fill_ff,     fill_in;
   logic [LEN_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [DCNT_W-1:0] div_cnt_ff,  div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // result register
   mean_type          mean_x_ff, mean_y_ff, mean_z_ff;
   logic              load_rsp;

   logic [CMP_W-1:0]  len_ext;
   logic [LEN_W-1:0]  n_act;
   logic [LEN_W-1:0]  divisor;
   logic [IDX_W-1:0]  tail_idx;
   logic              req_accept;
   logic              shift_en;
   logic              rotate;
   axis_ctrl_type     ctrl;

   triple_type        cell_d [WINDOW_MAX];
   triple_type        cell_q [WINDOW_MAX];
   triple_type        tail;
   mean_type          axis_mean [AXES];

   // clamp the written length into the supported range
   always_comb begin
      len_ext = CMP_W'(len_ff);
      if (len_ext < CMP_W'(LEN_MIN)) begin
         n_act = LEN_W'(LEN_MIN);
      end else if (len_ext > CMP_W'(WINDOW_MAX)) begin
         n_act = LEN_W'(WINDOW_MAX);
      end else begin
         n_act = LEN_W'(len_ext);
      end
      divisor  = n_act - LEN_W'(2);
      tail_idx = IDX_W'(n_act - LEN_W'(1));
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Window as a shift chain: the newest sample enters cell 0, the oldest sits at
   // cell n-1. During a scan the first n cells rotate once round, so the window ends back
   // in place and every sample has passed the tail once.
   assign tail = cell_q[tail_idx];

   assign cell_d[0] = rotate ? tail : {req_sample_z, req_sample_y, req_sample_x};

   for (genvar i = 1; i < WINDOW_MAX; i++) begin : g_link
      assign cell_d[i] = cell_q[i-1];
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      trm_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d        (cell_d[i]),
         .q        (cell_q[i])
      );
   end

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      trm_axis #(
         .WINDOW_MAX    (WINDOW_MAX),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_axis (
         .clock   (clock),
         .ctrl    (ctrl),
         .sample  (sample_type'(tail[a])),
         .divisor (divisor),
         .mean    (axis_mean[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= CSR_W'(WINDOW_RESET);
         fill_ff      <= '0;
         scan_cnt_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         // a length write restarts the fill phase
         if (csr_wr_en) begin
            len_ff  <= csr_wr_data;
            fill_ff <= '0;
         end else begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         mean_x_ff <= axis_mean[0];
         mean_y_ff <= axis_mean[1];
         mean_z_ff <= axis_mean[2];
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_cnt_in  = scan_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      load_rsp     = 1'b0;
      shift_en     = 1'b0;
      rotate       = 1'b0;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               shift_en = 1'b1;
               if (fill_ff != n_act) begin
                  fill_in = fill_ff + LEN_W'(1);
               end
               // window full after this request: start the scan
               if (fill_ff >= n_act - LEN_W'(1)) begin
                  ctrl.clear  = 1'b1;
                  scan_cnt_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            shift_en    = 1'b1;
            rotate      = 1'b1;
            ctrl.acc    = 1'b1;
            scan_cnt_in = scan_cnt_ff + LEN_W'(1);
            if (scan_cnt_ff == n_act - LEN_W'(1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctrl.load  = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            ctrl.step  = 1'b1;
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mean_x = mean_x_ff;
   assign rsp_mean_y = mean_y_ff;
   assign rsp_mean_z = mean_z_ff;

endmodule

`default_nettype wire

// ===== design/trm_checker.sv =====
`default_nettype none

module trm_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire trm_pkg::mean_type   rsp_mean_x
);
   import trm_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_x))
      else $error("stalled response changed");

   // a result appears only after the block was busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a busy phase");

   // leaving busy always leaves a result in the output register
   a_busy_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("busy phase ended without a response");

   // a request accepted straight after a busy phase finds a result in the output register
   a_no_accept_into_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && $past(req_stall) |-> rsp_valid)
      else $error("request accepted straight after busy without a response");

endmodule

bind trimmed_mean_window_filter_xyz trm_checker u_trm_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import trm_pkg::*;

   localparam int WINDOW_MAX     = 32;
   localparam int FRAC_BITS      = 8;
   // Longest busy stretch is the scan, trim, divide steps and load at n = 32; keep margin.
   localparam int SETTLE_CYCLES  = 2 * WINDOW_MAX + 16;
   // Cycles without any request or result taken before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      mean_type x;
      mean_type y;
      mean_type z;
   } axis_means_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   sample_type req_sample_x;
   sample_type req_sample_y;
   sample_type req_sample_z;
   logic       rsp_valid;
   logic       rsp_stall;
   mean_type   rsp_mean_x;
   mean_type   rsp_mean_y;
   mean_type   rsp_mean_z;
   logic       csr_wr_en;
   csr_type    csr_wr_data;

   // Mirror of the filter: window contents per axis, write slot, fill level, length register
   sample_type     window_mirror [AXES][WINDOW_MAX];
   int             slot_mirror;
   int             fill_mirror;
   csr_type        length_mirror;
   axis_means_type means_pending [$];

   int error_count;
   int quiet_cycles;
   int send_idle_pct;
   int recv_idle_pct;
   int recv_hold_cycles;

   trimmed_mean_window_filter_xyz #(
      .WINDOW_MAX    (WINDOW_MAX),
      .FRACTION_BITS (FRAC_BITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_x (req_sample_x),
      .req_sample_y (req_sample_y),
      .req_sample_z (req_sample_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_mean_x   (rsp_mean_x),
      .rsp_mean_y   (rsp_mean_y),
      .rsp_mean_z   (rsp_mean_z),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction helpers
   // ---------------------------------------------------------------------

   // Clamp the programmed length to the range the filter actually uses.
   function automatic int effective_length(input csr_type len);
      if (len < LEN_MIN)
         return LEN_MIN;
      if (len > WINDOW_MAX)
         return WINDOW_MAX;
      return int'(len);
   endfunction

   // Drop one smallest and one largest sample, scale by 2^FRAC_BITS, divide by n - 2
   // truncating toward zero, and saturate to the 24-bit result range.
   function automatic mean_type trimmed_mean(input int axis, input int n);
      longint     total;
      longint     quot;
      sample_type lo;
      sample_type hi;
      total = 0;
      lo    = window_mirror[axis][0];
      hi    = window_mirror[axis][0];
      for (int i = 0; i < n; i++) begin
         total += longint'(window_mirror[axis][i]);
         if (window_mirror[axis][i] < lo)
            lo = window_mirror[axis][i];
         if (window_mirror[axis][i] > hi)
            hi = window_mirror[axis][i];
      end
      total = total - longint'(lo) - longint'(hi);
      quot  = (total * (longint'(1) << FRAC_BITS)) / longint'(n - 2);
      if (quot > longint'(MEAN_MAX))
         quot = longint'(MEAN_MAX);
      if (quot < longint'(MEAN_MIN))
         quot = longint'(MEAN_MIN);
      return mean_type'(quot);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample at the rising edge, advance the mirror on every accepted
   // request or register write, and check each accepted result in order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : mirror_and_check
      int             n;
      int             slot;
      axis_means_type want;
      if (reset) begin
         slot_mirror   = 0;
         fill_mirror   = 0;
         length_mirror = csr_type'(WINDOW_RESET);
         means_pending.delete();
      end else begin
         // A length write restarts the fill phase; old samples are overwritten before use.
         if (csr_wr_en) begin
            length_mirror = csr_wr_data;
            slot_mirror   = 0;
            fill_mirror   = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (means_pending.size() == 0) begin
               report_error($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                      rsp_mean_x, rsp_mean_y, rsp_mean_z));
            end else begin
               want = means_pending.pop_front();
               if (rsp_mean_x !== want.x)
                  report_error($sformatf("mean_x got %0d expected %0d", rsp_mean_x, want.x));
               if (rsp_mean_y !== want.y)
                  report_error($sformatf("mean_y got %0d expected %0d", rsp_mean_y, want.y));
               if (rsp_mean_z !== want.z)
                  report_error($sformatf("mean_z got %0d expected %0d", rsp_mean_z, want.z));
            end
         end
         if (req_valid && !req_stall) begin
            n    = effective_length(length_mirror);
            slot = (slot_mirror >= n) ? 0 : slot_mirror;
            window_mirror[0][slot] = req_sample_x;
            window_mirror[1][slot] = req_sample_y;
            window_mirror[2][slot] = req_sample_z;
            slot_mirror = (slot + 1 >= n) ? 0 : slot + 1;
            if (fill_mirror < n)
               fill_mirror++;
            // Only a full window produces a result; the oldest sample is overwritten next.
            if (fill_mirror >= n) begin
               want.x = trimmed_mean(0, n);
               want.y = trimmed_mean(1, n);
               want.z = trimmed_mean(2, n);
               means_pending.push_back(want);
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: hold off for a requested stretch, otherwise stall at random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold_cycles > 0) begin
            rsp_stall = 1'b1;
            recv_hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus tasks; all start and end at a falling edge.
   // ---------------------------------------------------------------------

   // Offer one request after a random gap and hold it until the filter takes it.
   task automatic send_request(input sample_type x, input sample_type y, input sample_type z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_sample_x = x;
      req_sample_y = y;
      req_sample_z = z;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_results_drained();
      while (means_pending.size() != 0)
         @(negedge clock);
   endtask

   // Write the length only once the filter has gone quiet.
   task automatic write_window_length(input csr_type len);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = len;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Flavour 0: full range; 1: tight cluster round a centre; otherwise extreme-heavy.
   function automatic sample_type random_sample(input int flavour, input sample_type centre);
      case (flavour)
         0: return sample_type'($urandom);
         1: return centre + sample_type'($urandom_range(63)) - 16'sd32;
         default: begin
            case ($urandom_range(4))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               3:       return -16'sd1;
               default: return sample_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_random_run(input int count);
      int         flavour;
      sample_type centre;
      flavour = $urandom_range(2);
      centre  = sample_type'($urandom);
      repeat (count)
         send_request(random_sample(flavour, centre), random_sample(flavour, centre),
                      random_sample(flavour, centre));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset length of 12: extremes on x with repeated minima and maxima, y pinned at the
   // largest sample and z at the smallest to hit both ends of the result range.
   task automatic test_reset_length();
      sample_type xv;
      for (int i = 0; i < 13; i++) begin
         case (i % 4)
            0:       xv = SAMPLE_MAX;
            1:       xv = SAMPLE_MIN;
            2:       xv = '0;
            default: xv = -16'sd1;
         endcase
         send_request(xv, SAMPLE_MAX, SAMPLE_MIN);
      end
   endtask

   // Lengths below the minimum act as three; length five checks truncation toward zero.
   task automatic test_short_windows();
      write_window_length(csr_type'(0));
      send_request(16'sd5, 16'sd5, 16'sd5);
      send_request(-16'sd3, -16'sd3, 16'sd7);
      send_request(-16'sd3, 16'sd1, 16'sd8);
      send_request(16'sd2, -16'sd7, -16'sd7);
      write_window_length(csr_type'(5));
      send_request(-16'sd2, 16'sd1, SAMPLE_MIN);
      send_request(-16'sd1, 16'sd0, SAMPLE_MAX);
      send_request(16'sd0, 16'sd0, 16'sd1);
      send_request(16'sd0, 16'sd0, -16'sd2);
      send_request(16'sd3, 16'sd2, 16'sd0);
   endtask

   // Walk the length register through its edges, above-range values acting as the maximum.
   task automatic test_length_extremes();
      write_window_length(csr_type'(63));
      send_random_run(WINDOW_MAX + 8);
      write_window_length(csr_type'(WINDOW_MAX));
      send_random_run(WINDOW_MAX + 4);
      write_window_length(csr_type'(WINDOW_MAX + 1));
      send_random_run(WINDOW_MAX + 2);
      write_window_length(csr_type'(1));
      send_random_run(10);
      write_window_length(csr_type'(2));
      send_random_run(10);
      write_window_length(csr_type'(LEN_MIN));
      send_random_run(10);
   endtask

   // Hold the result side off while requests keep coming so the filter fills and stalls
   // its input; then pause the sender until every result is back.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_window_length(csr_type'(LEN_MIN));
      recv_hold_cycles = HOLD_CYCLES;
      send_random_run(10);
      wait_results_drained();
      send_random_run(6);
      wait_results_drained();
   endtask

   // Random segments, each after a fresh length write; small windows dominate.
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int total);
      int      sent;
      int      seg;
      csr_type len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(9))
            0:       len = csr_type'(0);
            1:       len = csr_type'(1);
            2:       len = csr_type'(2);
            3:       len = csr_type'(LEN_MIN);
            4:       len = csr_type'(WINDOW_MAX);
            5:       len = csr_type'(63);
            6:       len = csr_type'($urandom_range(WINDOW_MAX + 1, 62));
            default: len = csr_type'($urandom_range(4, 16));
         endcase
         write_window_length(len);
         seg = effective_length(len) + $urandom_range(10, 80);
         send_random_run(seg);
         sent += seg;
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_x     = '0;
      req_sample_y     = '0;
      req_sample_z     = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      error_count      = 0;
      quiet_cycles     = 0;
      send_idle_pct    = 25;
      recv_idle_pct    = 65;
      recv_hold_cycles = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_length();
      test_short_windows();
      test_length_extremes();
      test_output_backpressure();
      test_random_traffic(25, 65, 700);
      test_random_traffic(65, 25, 700);
      test_random_traffic(0, 0, 600);

      // Drain, then give the filter time to show any stray result.
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (means_pending.size() != 0)
         report_error($sformatf("%0d results never arrived", means_pending.size()));

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
design/trm_pkg.sv
design/trm_cell.sv
design/trm_axis.sv
design/trimmed_mean_window_filter_xyz.sv
design/trm_checker.sv
tb/sv/tb_top.sv
